>>> rtl/core/swsb_pkg.sv
// ============================================================================
// swsb_pkg - shared types and constants for the send window buffer
// Command and status codes, window sizing and the control/status bundles
// exchanged between the controller and the datapath.
// ============================================================================
package swsb_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam int CMD_W  = 3;
    localparam int SEQ_W  = 32;
    localparam int HDL_W  = 16;
    localparam int STS_W  = 3;
    localparam int WIN_W  = 5;
    localparam int RCNT_W = 5;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REM_OLD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_NEW = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_ACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd4;

    // status codes
    localparam logic [STS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STS_W-1:0] STS_FULL       = 3'd1;
    localparam logic [STS_W-1:0] STS_EMPTY      = 3'd2;
    localparam logic [STS_W-1:0] STS_SLOT_EMPTY = 3'd3;
    localparam logic [STS_W-1:0] STS_NOT_FOUND  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_SETUP,
        S_SCAN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the item
        logic norm;     // fold put index into window, clamp count
        logic setup;    // run commands that need no scan, arm the scan
        logic scan;     // advance the slot scan
        logic load;     // move result into the output register
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic put_ge_w;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/swsb_if.sv
// ============================================================================
// swsb_if - channel interfaces for the send window buffer
// Command input, result output and window size write channels.
// ============================================================================
interface swsb_in_if import swsb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] seq;
    logic [HDL_W-1:0] payload_handle;
    logic [SEQ_W-1:0] ack;

    modport source (output valid, cmd, seq, payload_handle, ack, input ready);
    modport sink   (input valid, cmd, seq, payload_handle, ack, output ready);
endinterface

interface swsb_out_if import swsb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [SEQ_W-1:0]  out_seq;
    logic [HDL_W-1:0]  out_handle;
    logic [RCNT_W-1:0] removed_count;

    modport source (output valid, status, out_seq, out_handle, removed_count, input ready);
    modport sink   (input valid, status, out_seq, out_handle, removed_count, output ready);
endinterface

interface swsb_cfg_if import swsb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] win_slots;

    modport source (output valid, win_slots, input ready);
    modport sink   (input valid, win_slots, output ready);
endinterface

>>> rtl/core/swsb_ctrl.sv
// ============================================================================
// swsb_ctrl - command sequencer
// Steps one item through normalize, setup, slot scan and result hand-off.
// ============================================================================
module swsb_ctrl import swsb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_NORM;
                end
            end
            S_NORM: begin
                // repeat until put index lies inside the window
                o_ctl.norm = 1'b1;
                if (!i_sts.put_ge_w) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_ctl.setup = 1'b1;
                n_state     = i_sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.scan = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/swsb_dp.sv
// ============================================================================
// swsb_dp - slot storage and scan datapath
// Slot memory, valid bits, put index, count, scan pipeline and result register.
// ============================================================================
module swsb_dp import swsb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    // item fields
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [HDL_W-1:0]  i_payload_handle,
    input  logic [SEQ_W-1:0]  i_ack,
    // window size write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WIN_W-1:0]  i_cfg_win_slots,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STS_W-1:0]  o_status,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [HDL_W-1:0]  o_out_handle,
    output logic [RCNT_W-1:0] o_removed_count
);

    logic [WIN_W-1:0]      r_window;
    logic [CMD_W-1:0]      r_cmd;
    logic [SEQ_W-1:0]      r_seq;
    logic [HDL_W-1:0]      r_handle;
    logic [SEQ_W-1:0]      r_ack;
    logic [CNT_W-1:0]      r_w;
    logic [IDX_W-1:0]      r_put;
    logic [CNT_W-1:0]      r_count;
    logic [MAX_WINDOW-1:0] r_valid;

    logic [SEQ_W-1:0]      r_mem_seq [MAX_WINDOW];
    logic [HDL_W-1:0]      r_mem_handle [MAX_WINDOW];
    logic [SEQ_W-1:0]      r_rd_seq;
    logic [HDL_W-1:0]      r_rd_handle;

    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_left;
    logic                  r_chk_vld;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_hit;

    logic [STS_W-1:0]      r_status;
    logic [SEQ_W-1:0]      r_oseq;
    logic [HDL_W-1:0]      r_ohandle;
    logic [RCNT_W-1:0]     r_removed;

    logic                  r_o_vld;
    logic [STS_W-1:0]      r_o_status;
    logic [SEQ_W-1:0]      r_o_seq;
    logic [HDL_W-1:0]      r_o_handle;
    logic [RCNT_W-1:0]     r_o_removed;

    logic [CNT_W-1:0]      w_eff;
    logic [CNT_W:0]        w_old_sum;
    logic [IDX_W-1:0]      w_oldest;
    logic [IDX_W-1:0]      w_newest;
    logic [IDX_W-1:0]      w_put_next;
    logic [IDX_W-1:0]      w_idx_next;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_add_wr;
    logic                  w_issue;
    logic                  w_check;
    logic                  w_chk_valid;

    // clamp the configured window into 1..MAX_WINDOW
    always_comb begin
        if (r_window == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_window) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(r_window);
        end
    end

    assign w_full     = (r_count == r_w);
    assign w_empty    = (r_count == '0);
    assign w_old_sum  = {1'b0, CNT_W'(r_put)} + {1'b0, r_w} - {1'b0, r_count};
    assign w_oldest   = (w_old_sum >= {1'b0, r_w}) ? IDX_W'(w_old_sum - {1'b0, r_w})
                                                   : IDX_W'(w_old_sum);
    assign w_newest   = (r_put == '0) ? IDX_W'(r_w - CNT_W'(1)) : r_put - IDX_W'(1);
    assign w_put_next = (CNT_W'(r_put) + CNT_W'(1) == r_w) ? '0 : r_put + IDX_W'(1);
    assign w_idx_next = (CNT_W'(r_idx) + CNT_W'(1) == r_w) ? '0 : r_idx + IDX_W'(1);
    assign w_add_wr   = i_ctl.setup && (r_cmd == CMD_ADD) && !w_full;
    assign w_issue    = i_ctl.scan && (r_left != '0) && !r_hit;
    assign w_check    = i_ctl.scan && r_chk_vld && !r_hit;
    assign w_chk_valid = r_valid[r_chk_idx];

    assign o_sts.put_ge_w  = (CNT_W'(r_put) >= r_w);
    assign o_sts.need_scan = (r_cmd == CMD_REM_ACK)
                          || (!w_empty && (r_cmd == CMD_REM_OLD || r_cmd == CMD_REM_NEW
                                           || r_cmd == CMD_LOOKUP));
    assign o_sts.scan_done = r_hit || ((r_left == '0) && !r_chk_vld);
    assign o_sts.out_free  = !r_o_vld || i_out_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_win_slots;
        end
    end

    // slot memory: one write port for add, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_add_wr) begin
            r_mem_seq[r_put]    <= r_seq;
            r_mem_handle[r_put] <= r_handle;
        end
        r_rd_seq    <= r_mem_seq[r_idx];
        r_rd_handle <= r_mem_handle[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd    <= i_cmd;
            r_seq    <= i_seq;
            r_handle <= i_payload_handle;
            r_ack    <= i_ack;
            r_w      <= w_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_put     <= '0;
            r_count   <= '0;
            r_valid   <= '0;
            r_idx     <= '0;
            r_left    <= '0;
            r_chk_vld <= 1'b0;
            r_chk_idx <= '0;
            r_hit     <= 1'b0;
            r_status  <= STS_OK;
            r_oseq    <= '0;
            r_ohandle <= '0;
            r_removed <= '0;
        end else begin
            if (i_ctl.norm) begin
                if (CNT_W'(r_put) >= r_w) begin
                    r_put <= IDX_W'(CNT_W'(r_put) - r_w);
                end
                if (r_count > r_w) begin
                    r_count <= r_w;
                end
            end

            if (i_ctl.setup) begin
                r_status  <= STS_OK;
                r_oseq    <= '0;
                r_ohandle <= '0;
                r_removed <= '0;
                r_hit     <= 1'b0;
                r_chk_vld <= 1'b0;
                r_left    <= '0;
                r_idx     <= w_oldest;
                case (r_cmd)
                    CMD_ADD: begin
                        if (w_full) begin
                            r_status <= STS_FULL;
                        end else begin
                            r_valid[r_put] <= 1'b1;
                            r_count        <= r_count + CNT_W'(1);
                            r_put          <= w_put_next;
                        end
                    end
                    CMD_REM_OLD: begin
                        if (w_empty) begin
                            r_status <= STS_EMPTY;
                        end else begin
                            r_left <= CNT_W'(1);
                        end
                    end
                    CMD_REM_NEW: begin
                        if (w_empty) begin
                            r_status <= STS_EMPTY;
                        end else begin
                            r_idx  <= w_newest;
                            r_left <= CNT_W'(1);
                            r_put  <= w_newest;
                        end
                    end
                    CMD_REM_ACK: begin
                        r_left <= r_count;
                    end
                    CMD_LOOKUP: begin
                        if (w_empty) begin
                            r_status <= STS_EMPTY;
                        end else begin
                            r_status <= STS_NOT_FOUND;
                            r_left   <= r_count;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_ctl.scan) begin
                // issue stage: read the next slot
                r_chk_vld <= w_issue;
                if (w_issue) begin
                    r_chk_idx <= r_idx;
                    r_idx     <= w_idx_next;
                    r_left    <= r_left - CNT_W'(1);
                end
            end

            if (w_check) begin
                // check stage: act on the slot read last cycle
                case (r_cmd)
                    CMD_REM_OLD, CMD_REM_NEW: begin
                        if (w_chk_valid) begin
                            r_oseq               <= r_rd_seq;
                            r_valid[r_chk_idx]   <= 1'b0;
                            if (r_count != '0) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end else begin
                            r_status <= STS_SLOT_EMPTY;
                        end
                    end
                    CMD_REM_ACK: begin
                        if (w_chk_valid && (r_rd_seq < r_ack)) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_removed          <= r_removed + RCNT_W'(1);
                            if (r_count != '0) begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                    end
                    CMD_LOOKUP: begin
                        if (!w_chk_valid) begin
                            r_status <= STS_SLOT_EMPTY;
                            r_hit    <= 1'b1;
                        end else if (r_rd_seq == r_seq) begin
                            r_status  <= STS_OK;
                            r_oseq    <= r_rd_seq;
                            r_ohandle <= r_rd_handle;
                            r_hit     <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_ctl.load) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_o_status  <= r_status;
            r_o_seq     <= r_oseq;
            r_o_handle  <= r_ohandle;
            r_o_removed <= r_removed;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_status        = r_o_status;
    assign o_out_seq       = r_o_seq;
    assign o_out_handle    = r_o_handle;
    assign o_removed_count = r_o_removed;

endmodule

>>> rtl/core/sliding_window_send_buffer.sv
// ============================================================================
// sliding_window_send_buffer - retransmit window of sequence/handle slots
// Circular buffer of up to 16 slots with add, remove oldest, remove newest,
// remove below cumulative ack and lookup by sequence number.
// ============================================================================
//
//  Channel   Dir  Handshake      Payload
//  i_in      in   valid/ready    cmd, seq, payload_handle, ack
//  i_cfg     in   valid/ready    win_slots (always ready)
//  o_out     out  valid/ready    status, out_seq, out_handle, removed_count
//
//  Steps per item: intake, normalize, setup, hand-off; commands that read
//  slots add a scan between setup and hand-off: remove oldest/newest read one
//  slot, remove-below-ack and lookup up to r_count slots. A shrunken window
//  repeats normalize, folding a window length out of the put index each time.
//  Reset: synchronous, active low; clears valid marks, put index and count,
//  window back to 16, slot contents kept. Stalls: a held result holds the next
//  item at its hand-off, and intake stays closed until that item is loaded.
//
module sliding_window_send_buffer import swsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swsb_in_if.sink     i_in,
    swsb_cfg_if.sink    i_cfg,
    swsb_out_if.source  o_out
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // sequencer: one item in flight between intake and output register
    swsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // storage, scan pipeline and output register
    swsb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_cmd             (i_in.cmd),
        .i_seq             (i_in.seq),
        .i_payload_handle  (i_in.payload_handle),
        .i_ack             (i_in.ack),
        .i_cfg_valid       (i_cfg.valid),
        .o_cfg_ready       (i_cfg.ready),
        .i_cfg_win_slots   (i_cfg.win_slots),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_status          (o_out.status),
        .o_out_seq         (o_out.out_seq),
        .o_out_handle      (o_out.out_handle),
        .o_removed_count   (o_out.removed_count)
    );

endmodule

>>> dv/tb_sliding_window_send_buffer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sliding_window_send_buffer - self-checking bench for the send window
// Drives command items with random gaps, runs a cycle-free model of the slot
// window to work out each reply, and compares every reply field by field.
// Sweeps the window size, including out-of-range values, between phases.
// ============================================================================
module tb_sliding_window_send_buffer;
    import swsb_pkg::*;

    localparam int SETTLE_CYCLES = 48;     // full scan plus worst put index fold
    localparam int HOLD_START    = 130;    // items taken before the long stall
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 75;
    localparam int WRAP_PHASE    = 4;      // phase whose sequence numbers wrap

    // anything above the last real command leaves the slots as they are and gets an OK reply
    localparam logic [CMD_W-1:0] CMD_TOP_UNUSED = '1;

    localparam logic [WIN_W-1:0] WIN_PLAN [10] = '{
        5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12, 5'd1, 5'd16
    };

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] seq;
        logic [HDL_W-1:0] handle;
        logic [SEQ_W-1:0] ack;
    } t_cmd_item;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [SEQ_W-1:0]  seq;
        logic [HDL_W-1:0]  handle;
        logic [RCNT_W-1:0] removed;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    swsb_in_if  in_if ();
    swsb_out_if out_if ();
    swsb_cfg_if cfg_if ();

    sliding_window_send_buffer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // model state of the window
    logic [WIN_W-1:0] win_reg;
    bit               slot_used [MAX_WINDOW];
    logic [SEQ_W-1:0] slot_sn   [MAX_WINDOW];
    logic [HDL_W-1:0] slot_hdl  [MAX_WINDOW];
    int unsigned      put_ptr;
    int unsigned      fill_cnt;

    t_cmd_item   cmd_q [$];     // commands not yet offered
    t_reply      owed_q [$];    // replies the block still owes, oldest first
    logic [SEQ_W-1:0] next_sn;  // running sequence number for well-formed traffic

    bit          in_taken;
    bit          out_taken;
    bit          hold_off;
    bit          tx_steady;
    bit          rx_steady;
    int unsigned tx_wait;
    int unsigned rx_wait;
    int unsigned items_in;
    int unsigned err_cnt;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one command to the model window and return the reply it owes.
    function automatic t_reply run_window_cmd(input t_cmd_item it);
        t_reply      r;
        int unsigned w, p, c, oldest, idx, i, removed;
        bit          stop;
        r       = '0;
        removed = 0;
        stop    = 1'b0;
        w = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
        // fold put index and clamp count into a window that may have shrunk
        p        = put_ptr % w;
        c        = (fill_cnt > w) ? w : fill_cnt;
        oldest   = (p + w - c) % w;
        put_ptr  = p;
        fill_cnt = c;
        r.status = STS_OK;
        case (it.cmd)
            CMD_ADD: begin
                if (c == w) begin
                    r.status = STS_FULL;
                end else begin
                    slot_used[p] = 1'b1;
                    slot_sn[p]   = it.seq;
                    slot_hdl[p]  = it.handle;
                    fill_cnt     = c + 1;
                    put_ptr      = (p + 1) % w;
                end
            end
            CMD_REM_OLD, CMD_REM_NEW: begin
                if (c == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    idx = (it.cmd == CMD_REM_OLD) ? oldest : (p + w - 1) % w;
                    if (slot_used[idx]) begin
                        r.seq          = slot_sn[idx];
                        slot_used[idx] = 1'b0;
                        if (fill_cnt > 0) fill_cnt--;
                    end else begin
                        r.status = STS_SLOT_EMPTY;
                    end
                    // newest removal backs the put index up even over a hole
                    if (it.cmd == CMD_REM_NEW) put_ptr = idx;
                end
            end
            CMD_REM_ACK: begin
                for (i = 0; i < c; i++) begin
                    idx = (oldest + i) % w;
                    if (slot_used[idx] && slot_sn[idx] < it.ack) begin
                        slot_used[idx] = 1'b0;
                        if (fill_cnt > 0) fill_cnt--;
                        removed++;
                    end
                end
                r.removed = RCNT_W'(removed);
            end
            CMD_LOOKUP: begin
                if (c == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.status = STS_NOT_FOUND;
                    for (i = 0; i < c && !stop; i++) begin
                        idx = (oldest + i) % w;
                        if (!slot_used[idx]) begin
                            r.status = STS_SLOT_EMPTY;
                            stop     = 1'b1;
                        end else if (slot_sn[idx] == it.seq) begin
                            r.status = STS_OK;
                            r.seq    = slot_sn[idx];
                            r.handle = slot_hdl[idx];
                            stop     = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mostly in-order traffic around next_sn; some fully random fields to
    // leave holes in the window and to toggle every bit.
    function automatic t_cmd_item make_cmd();
        t_cmd_item   it;
        int unsigned pick;
        pick      = $urandom_range(0, 99);
        it.seq    = $urandom;
        it.handle = HDL_W'($urandom);
        it.ack    = $urandom;
        if (pick < 40) begin
            it.cmd = CMD_ADD;
            if ($urandom_range(0, 4) != 0) begin
                it.seq  = next_sn;
                next_sn = next_sn + 1;
            end
        end else if (pick < 50) begin
            it.cmd = CMD_REM_OLD;
        end else if (pick < 60) begin
            it.cmd = CMD_REM_NEW;
        end else if (pick < 75) begin
            it.cmd = CMD_REM_ACK;
            if ($urandom_range(0, 4) != 0) it.ack = next_sn - $urandom_range(0, 18);
        end else if (pick < 95) begin
            it.cmd = CMD_LOOKUP;
            if ($urandom_range(0, 4) != 0) it.seq = next_sn - $urandom_range(1, 18);
        end else begin
            it.cmd = CMD_W'($urandom_range(int'(CMD_LOOKUP) + 1, int'(CMD_TOP_UNUSED)));
        end
        return it;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [SEQ_W-1:0] s,
                             input logic [HDL_W-1:0] h, input logic [SEQ_W-1:0] a);
        cmd_q.push_back('{c, s, h, a});
    endtask

    // Wait until every command is in and every reply is out, then let the
    // block drain its pipeline.
    task automatic settle();
        while (cmd_q.size() != 0 || in_if.valid !== 1'b0 || owed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.win_slots <= w;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        win_reg = w;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Command driver: hold the item until taken, then wait out the drawn gap.
    always @(negedge i_clk) begin : tx_side
        t_cmd_item it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                in_if.valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                it = cmd_q.pop_front();
                in_if.valid          <= 1'b1;
                in_if.cmd            <= it.cmd;
                in_if.seq            <= it.seq;
                in_if.payload_handle <= it.handle;
                in_if.ack            <= it.ack;
                if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
                tx_wait = tx_steady ? 0 : $urandom_range(0, 9);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Reply receiver: stall a drawn number of cycles after each reply, and
    // drop ready entirely while the long hold-off runs.
    always @(negedge i_clk) begin : rx_side
        int unsigned nxt;
        nxt = rx_wait;
        if (out_taken) begin
            if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
            nxt = rx_steady ? 0 : $urandom_range(0, 9);
        end else if (nxt > 0) begin
            nxt--;
        end
        rx_wait = nxt;
        out_if.ready <= i_rst_n && (nxt == 0) && !hold_off;
    end

    // Long receiver stall while the sender keeps offering, so the block
    // backs up and stalls its input.
    initial begin : rx_hold
        while (items_in < HOLD_START) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor: predict on each command taken, check on each reply taken.
    always @(posedge i_clk) begin : mon
        t_reply got;
        t_reply want;
        in_taken  <= (in_if.valid && in_if.ready) === 1'b1;
        out_taken <= (out_if.valid && out_if.ready) === 1'b1;
        if ((in_if.valid && in_if.ready) === 1'b1) begin
            owed_q.push_back(run_window_cmd('{in_if.cmd, in_if.seq,
                                              in_if.payload_handle, in_if.ack}));
            items_in++;
        end
        if ((out_if.valid && out_if.ready) === 1'b1) begin
            got = '{out_if.status, out_if.out_seq, out_if.out_handle, out_if.removed_count};
            if (owed_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: reply with nothing outstanding: status %0d seq %h",
                             $realtime, got.status, got.seq);
            end else begin
                want = owed_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $write("%0t: reply mismatch (exp/got) status %0d/%0d ",
                               $realtime, want.status, got.status);
                        $display("seq %h/%h handle %h/%h removed %0d/%0d",
                                 want.seq, got.seq, want.handle, got.handle,
                                 want.removed, got.removed);
                    end
                end
            end
        end
    end

    initial begin : stim
        int ph, n;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.cmd            = CMD_ADD;
        in_if.seq            = '0;
        in_if.payload_handle = '0;
        in_if.ack            = '0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.win_slots     = WINDOW_RESET;
        win_reg              = WINDOW_RESET;
        put_ptr              = 0;
        fill_cnt             = 0;
        foreach (slot_used[k]) slot_used[k] = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty window: every removal and lookup on nothing, and a junk code
        queue_cmd(CMD_REM_OLD, '0, '0, '0);
        queue_cmd(CMD_REM_NEW, '0, '0, '0);
        queue_cmd(CMD_LOOKUP, '0, '0, '0);
        queue_cmd(CMD_REM_ACK, '0, '0, '1);
        queue_cmd(CMD_TOP_UNUSED, '1, '1, '1);
        // field extremes, then hits and misses
        queue_cmd(CMD_ADD, '0, '0, '0);
        queue_cmd(CMD_ADD, '1, '1, '0);
        queue_cmd(CMD_ADD, 32'd5, 16'h1234, '0);
        queue_cmd(CMD_LOOKUP, '1, '0, '0);
        queue_cmd(CMD_LOOKUP, 32'd9, '0, '0);
        // ack clears both ends and leaves the oldest slot empty inside the range
        queue_cmd(CMD_REM_ACK, '0, '0, 32'd6);
        queue_cmd(CMD_LOOKUP, '1, '0, '0);
        queue_cmd(CMD_REM_OLD, '0, '0, '0);
        // newest is the hole: put index still backs up, then the real entry goes
        queue_cmd(CMD_REM_NEW, '0, '0, '0);
        queue_cmd(CMD_REM_NEW, '0, '0, '0);
        settle();

        // single slot: fill, overflow, hit, drain, underflow
        write_window(5'd1);
        queue_cmd(CMD_ADD, 32'd3, 16'hA5A5, '0);
        queue_cmd(CMD_ADD, 32'd4, 16'h5A5A, '0);
        queue_cmd(CMD_LOOKUP, 32'd3, '0, '0);
        queue_cmd(CMD_REM_NEW, '0, '0, '0);
        queue_cmd(CMD_REM_OLD, '0, '0, '0);
        settle();

        // random phases over a sweep of window sizes; state carries across,
        // so shrinking exercises the put index fold and count clamp
        for (ph = 0; ph < $size(WIN_PLAN); ph++) begin
            write_window(WIN_PLAN[ph]);
            next_sn = (ph == WRAP_PHASE) ? 32'hFFFF_FFF0 : $urandom;
            for (n = 0; n < PHASE_ITEMS; n++) cmd_q.push_back(make_cmd());
            settle();
        end

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
